// ===== rtl/core/dtss_pkg.sv =====
// Shared types, codes and constants of the delayed task slot scheduler.
`default_nettype none
package dtss_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_STAT    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SUBMIT   = 2'd0,
    KIND_TASK     = 2'd1,
    KIND_ADV_DONE = 2'd2,
    KIND_STAT     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_TICK     = 3'd0,
    STAT_PENDING  = 3'd1,
    STAT_MAXPEND  = 3'd2,
    STAT_OVERFLOW = 3'd3,
    STAT_IMMED    = 3'd4,
    STAT_SUBMITS  = 3'd5,
    STAT_DISPATCH = 3'd6,
    STAT_FAILED   = 3'd7
  } stat_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_CHECK,
    ST_OUT,
    ST_WAIT
  } state_t;

  // Register index of the zero-delay post mode bit.
  localparam logic [0:0] REG_POST_MODE = 1'b0;
  // Byte address of the zero-delay post mode register.
  localparam logic [1:0] ADDR_POST_MODE = 2'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take the input beat
    logic do_submit;   // submit bookkeeping and slot write
    logic do_advance;  // add ticks to the counter
    logic scan_clear;  // reset the scan index and dispatch count
    logic scan_read;   // read the slot at the scan index
    logic scan_next;   // step the scan index
    logic dispatch;    // dispatch the current slot
    logic fail;        // count a failed dispatch
    logic load_imm;    // load the immediate task beat
    logic load_final;  // load the final beat of the command
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       immediate;
    logic       scan_last;
    logic       slot_due;
    logic       room_left;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/dtss_ctrl.sv =====
// Controller state machine of the delayed task slot scheduler.
`default_nettype none
module dtss_ctrl
  import dtss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  output logic      in_tready,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          ctl.capture = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.out_busy) begin
          case (sts.cmd)
            CMD_SUBMIT: begin
              if (sts.immediate) begin
                ctl.load_imm = 1'b1;
                state_nxt = ST_WAIT;
              end else begin
                ctl.do_submit = 1'b1;
                ctl.load_final = 1'b1;
                state_nxt = ST_IDLE;
              end
            end
            CMD_ADVANCE: begin
              ctl.do_advance = 1'b1;
              ctl.scan_clear = 1'b1;
              state_nxt = ST_READ;
            end
            CMD_STAT: begin
              ctl.load_final = 1'b1;
              state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WAIT: begin
        // Immediate task beat out; now send the submit status.
        if (!sts.out_busy) begin
          ctl.do_submit = 1'b1;
          ctl.load_final = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        ctl.scan_read = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.slot_due && sts.room_left) begin
          if (!sts.out_busy) begin
            ctl.dispatch = 1'b1;
            state_nxt = ST_OUT;
          end
        end else begin
          if (sts.slot_due) begin
            ctl.fail = 1'b1;
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.scan_last) begin
          if (!sts.out_busy) begin
            ctl.load_final = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          ctl.scan_next = 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dtss_dp.sv =====
// Datapath of the delayed task slot scheduler: slot table, counters, output register.
`default_nettype none
module dtss_dp
  import dtss_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [169:0] in_data,
  input  wire logic         post_mode,
  input  wire ctl_t         ctl,
  output sts_t              sts,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [167:0]      out_data,
  output logic              out_last
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Captured input fields.
  logic [1:0]  cmd_r;
  logic [31:0] code_r, ctx_r, param_r, delay_r, amt_r;
  logic [4:0]  room_r;
  logic [2:0]  sidx_r;

  // Slot table: valid bits in flops, due ticks and payload in memory.
  logic [SLOTS-1:0] valid_r;
  logic [63:0] due_mem [SLOTS];
  logic [31:0] code_mem [SLOTS];
  logic [31:0] ctx_mem [SLOTS];
  logic [31:0] param_mem [SLOTS];
  logic [63:0] rd_due_r;
  logic [31:0] rd_code_r, rd_ctx_r, rd_param_r;
  logic        rd_valid_r;

  logic [63:0] tick_r;
  logic [CW-1:0] pend_r, maxp_r;
  logic [31:0] ovf_r, imm_r, sub_r, disp_r, fail_r;
  logic [IW-1:0] scan_r;
  logic [4:0]  cnt_r;

  logic        full;
  logic [IW-1:0] free_idx;
  logic [63:0] stat_val;
  logic [CW-1:0] pend_inc;
  logic        out_take;

  // First free slot, priority from the lowest index.
  always_comb begin
    full = 1'b1;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        full = 1'b0;
        free_idx = IW'(i);
      end
    end
  end

  assign pend_inc = pend_r + CW'(1);

  // Statistic select.
  always_comb begin
    case (stat_idx_t'(sidx_r))
      STAT_TICK:     stat_val = tick_r;
      STAT_PENDING:  stat_val = 64'(pend_r);
      STAT_MAXPEND:  stat_val = 64'(maxp_r);
      STAT_OVERFLOW: stat_val = {32'd0, ovf_r};
      STAT_IMMED:    stat_val = {32'd0, imm_r};
      STAT_SUBMITS:  stat_val = {32'd0, sub_r};
      STAT_DISPATCH: stat_val = {32'd0, disp_r};
      default:       stat_val = {32'd0, fail_r};
    endcase
  end

  assign sts.cmd       = cmd_r;
  assign sts.immediate = (delay_r == 32'd0) && !post_mode;
  assign sts.scan_last = (scan_r == IW'(SLOTS - 1));
  assign sts.slot_due  = rd_valid_r && (rd_due_r <= tick_r);
  assign sts.room_left = (room_r != 5'd0);
  assign sts.out_busy  = out_tvalid && !out_tready;
  assign out_take      = out_tvalid && out_tready;

  // Input capture, scan state, slot read and slot write.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r   <= in_data[1:0];
      code_r  <= in_data[33:2];
      ctx_r   <= in_data[65:34];
      param_r <= in_data[97:66];
      delay_r <= in_data[129:98];
      amt_r   <= in_data[161:130];
      room_r  <= in_data[166:162];
      sidx_r  <= in_data[169:167];
    end
    if (ctl.scan_clear) begin
      scan_r <= '0;
      cnt_r  <= '0;
    end
    if (ctl.scan_next) begin
      scan_r <= scan_r + IW'(1);
    end
    if (ctl.dispatch) begin
      room_r <= room_r - 5'd1;
      cnt_r  <= cnt_r + 5'd1;
    end
    if (ctl.scan_read) begin
      rd_due_r   <= due_mem[scan_r];
      rd_code_r  <= code_mem[scan_r];
      rd_ctx_r   <= ctx_mem[scan_r];
      rd_param_r <= param_mem[scan_r];
      rd_valid_r <= valid_r[scan_r];
    end
    if (ctl.do_submit && !sts.immediate && !full) begin
      due_mem[free_idx]   <= tick_r + {32'd0, delay_r};
      code_mem[free_idx]  <= code_r;
      ctx_mem[free_idx]   <= ctx_r;
      param_mem[free_idx] <= param_r;
    end
  end

  // Control state: valid bits, tick and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      tick_r  <= '0;
      pend_r  <= '0;
      maxp_r  <= '0;
      ovf_r   <= '0;
      imm_r   <= '0;
      sub_r   <= '0;
      disp_r  <= '0;
      fail_r  <= '0;
    end else begin
      if (ctl.do_advance) begin
        tick_r <= tick_r + {32'd0, amt_r};
      end
      if (ctl.do_submit) begin
        if (sts.immediate) begin
          imm_r <= imm_r + 32'd1;
          sub_r <= sub_r + 32'd1;
        end else if (full) begin
          ovf_r <= ovf_r + 32'd1;
        end else begin
          valid_r[free_idx] <= 1'b1;
          pend_r <= pend_inc;
          if (pend_inc > maxp_r) begin
            maxp_r <= pend_inc;
          end
          sub_r <= sub_r + 32'd1;
        end
      end
      if (ctl.dispatch) begin
        valid_r[scan_r] <= 1'b0;
        pend_r <= pend_r - CW'(1);
        disp_r <= disp_r + 32'd1;
      end
      if (ctl.fail) begin
        fail_r <= fail_r + 32'd1;
      end
    end
  end

  // Output register: kind, status, code, context, param, count, stat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (ctl.load_imm || ctl.dispatch || ctl.load_final) begin
      out_tvalid <= 1'b1;
    end else if (out_take) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_imm) begin
      out_data <= {64'd0, 5'd0, param_r, ctx_r, code_r, 1'b0, KIND_TASK};
      out_last <= 1'b0;
    end else if (ctl.dispatch) begin
      out_data <= {64'd0, 5'd0, rd_param_r, rd_ctx_r, rd_code_r, 1'b0, KIND_TASK};
      out_last <= 1'b0;
    end else if (ctl.load_final) begin
      out_last <= 1'b1;
      case (cmd_t'(cmd_r))
        CMD_ADVANCE:
          out_data <= {64'd0, cnt_r, 96'd0, 1'b0, KIND_ADV_DONE};
        CMD_STAT:
          out_data <= {stat_val, 5'd0, 96'd0, 1'b0, KIND_STAT};
        default:
          out_data <= {64'd0, 5'd0, 96'd0,
                       !sts.immediate && full, KIND_SUBMIT};
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/delayed_task_slot_scheduler.sv =====
// Top level of the delayed task slot scheduler.
//
// Channel | Direction | Content
// in_     | slave     | tdata: cmd, task_code, task_context, task_param, delay,
//         |           |        tick_amount, handler_room, stat_index
// out_    | master    | tdata: kind, status, out_code, out_context, out_param,
//         |           |        dispatch_count, stat_value; tlast: last
// cfg_    | APB       | register 0 at address 0: zero-delay post mode
//
// A submit or statistic read passes DECODE and returns to IDLE; an immediate submit also passes WAIT.
// An advance visits every slot through READ, CHECK and OUT; the scan reads one slot per visit.
// One item is in work at a time; a stalled result beat holds the scan.
// Reset is synchronous and clears the table's valid bits at once.
`default_nettype none
module delayed_task_slot_scheduler
  import dtss_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd[1:0], task_code[33:2], task_context[65:34], task_param[97:66],
  // delay[129:98], tick_amount[161:130], handler_room[166:162],
  // stat_index[169:167], zero fill
  input  wire logic [175:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // kind[1:0], status[2], out_code[34:3], out_context[66:35],
  // out_param[98:67], dispatch_count[103:99], stat_value[167:104]
  output logic [167:0]      out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  ctl_t ctl;
  sts_t sts;
  logic post_r;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_POST_MODE) ? {31'd0, post_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_POST_MODE) begin
      post_r <= cfg_pwdata[0];
    end
  end

  dtss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  dtss_dp #(.SLOTS(SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata[169:0]),
    .post_mode  (post_r),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

// ===== test/delayed_task_slot_scheduler_tb.sv =====
// Testbench for the delayed task slot scheduler: random and directed commands checked by a scoreboard.
`timescale 1ns / 1ps
module delayed_task_slot_scheduler_tb;
  import dtss_pkg::*;

  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] code;
    logic [31:0] ctx;
    logic [31:0] param;
    logic [31:0] delay;
    logic [31:0] amount;
    logic [4:0]  room;
    logic [2:0]  sidx;
  } cmd_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [31:0] code;
    logic [31:0] ctx;
    logic [31:0] param;
    logic [4:0]  count;
    logic [63:0] stat;
    logic        last;
  } res_beat_t;

  // Scoreboard: a shadow copy of the slot table and counters.
  class sched_scoreboard;
    bit          post_mode;
    bit          busy_slot[NSLOT];
    logic [63:0] due[NSLOT];
    logic [31:0] s_code[NSLOT], s_ctx[NSLOT], s_param[NSLOT];
    logic [63:0] tick;
    int unsigned pend, max_pend;
    logic [31:0] n_ovf, n_imm, n_sub, n_disp, n_fail;
    res_beat_t   pending_res[$];
    int          errors;

    function void clear();
      post_mode = 0;
      foreach (busy_slot[i]) busy_slot[i] = 0;
      tick = 0; pend = 0; max_pend = 0;
      n_ovf = 0; n_imm = 0; n_sub = 0; n_disp = 0; n_fail = 0;
      pending_res.delete();
      errors = 0;
    endfunction

    function void push(logic [1:0] k, logic st, logic [31:0] c, logic [31:0] x,
                       logic [31:0] p, logic [4:0] n, logic [63:0] v, logic l);
      res_beat_t r;
      r = '{kind: k, status: st, code: c, ctx: x, param: p, count: n, stat: v, last: l};
      pending_res.push_back(r);
    endfunction

    function void note_input(cmd_beat_t b);
      int slot;
      int rm;
      int cnt;
      logic [63:0] sv;
      slot = -1;
      rm = b.room;
      cnt = 0;
      case (b.cmd)
        CMD_SUBMIT: begin
          if (b.delay == 0 && !post_mode) begin
            push(KIND_TASK, 0, b.code, b.ctx, b.param, 0, 0, 0);
            n_imm++; n_sub++;
            push(KIND_SUBMIT, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            for (int i = NSLOT - 1; i >= 0; i--) if (!busy_slot[i]) slot = i;
            if (slot < 0) begin
              n_ovf++;
              push(KIND_SUBMIT, 1, 0, 0, 0, 0, 0, 1);
            end else begin
              pend++;
              if (pend > max_pend) max_pend = pend;
              busy_slot[slot] = 1;
              s_code[slot] = b.code; s_ctx[slot] = b.ctx; s_param[slot] = b.param;
              due[slot] = tick + 64'(b.delay);
              n_sub++;
              push(KIND_SUBMIT, 0, 0, 0, 0, 0, 0, 1);
            end
          end
        end
        CMD_ADVANCE: begin
          tick = tick + 64'(b.amount);
          for (int i = 0; i < NSLOT; i++) begin
            if (busy_slot[i] && due[i] <= tick) begin
              if (rm > 0) begin
                rm--;
                push(KIND_TASK, 0, s_code[i], s_ctx[i], s_param[i], 0, 0, 0);
                busy_slot[i] = 0; pend--; n_disp++; cnt++;
              end else begin
                n_fail++;
              end
            end
          end
          push(KIND_ADV_DONE, 0, 0, 0, 0, cnt[4:0], 0, 1);
        end
        CMD_STAT: begin
          case (stat_idx_t'(b.sidx))
            STAT_TICK:     sv = tick;
            STAT_PENDING:  sv = pend;
            STAT_MAXPEND:  sv = max_pend;
            STAT_OVERFLOW: sv = n_ovf;
            STAT_IMMED:    sv = n_imm;
            STAT_SUBMITS:  sv = n_sub;
            STAT_DISPATCH: sv = n_disp;
            default:       sv = n_fail;
          endcase
          push(KIND_STAT, 0, 0, 0, 0, 0, sv, 1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_beat_t got);
      res_beat_t want;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending_res.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [167:0] out_tdata;
  logic         out_tlast;
  logic         cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  sched_scoreboard sb;
  bit  calm;
  int  quiet_cycles;

  delayed_task_slot_scheduler uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  always #1 clk = ~clk;

  // Result side: check every accepted beat and stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tlast, out_tdata[167:104], out_tdata[103:99],
                       out_tdata[98:67], out_tdata[66:35], out_tdata[34:3],
                       out_tdata[2], out_tdata[1:0]} == 0 ? res_beat_t'(0) :
                      res_beat_t'{kind: out_tdata[1:0], status: out_tdata[2],
                       code: out_tdata[34:3], ctx: out_tdata[66:35],
                       param: out_tdata[98:67], count: out_tdata[103:99],
                       stat: out_tdata[167:104], last: out_tlast});
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_post_mode(bit v);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= ADDR_POST_MODE;
    cfg_pwdata <= {$urandom() & 32'hFFFF_FFFE} | v;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    sb.post_mode = v;
  endtask

  task automatic send_beat(cmd_beat_t b);
    int gap;
    // Start on a falling edge after the one that released the previous beat; a random gap may come first.
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {6'd0, b.sidx, b.room, b.amount, b.delay, b.param, b.ctx, b.code, b.cmd};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  // Wait until every expected beat is back, then a little longer.
  task automatic drain();
    while (sb.pending_res.size() != 0) @(posedge clk);
    repeat (3 * NSLOT + 10) @(posedge clk);
  endtask

  function automatic cmd_beat_t rand_beat(int bias);
    cmd_beat_t b;
    b.cmd = 2'($urandom_range(0, 9) < 5 ? CMD_SUBMIT :
               ($urandom_range(0, 9) < 7 ? CMD_ADVANCE : CMD_STAT));
    if ($urandom_range(0, 40) == 0) b.cmd = CMD_NONE;
    b.code = $urandom(); b.ctx = $urandom(); b.param = $urandom();
    case ($urandom_range(0, 5))
      0: b.delay = 0;
      1: b.delay = $urandom();
      default: b.delay = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 6))
      0: b.amount = 0;
      1: b.amount = $urandom();
      default: b.amount = $urandom_range(0, 30);
    endcase
    b.room = $urandom_range(0, 6) == 0 ? 5'($urandom()) : 5'($urandom_range(0, bias));
    b.sidx = 3'($urandom());
    return b;
  endfunction

  initial begin
    cmd_beat_t b;
    sb = new();
    sb.clear();
    calm = 0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;

    // Directed: immediate dispatch, extremes, full table, stats.
    b = '{cmd: CMD_SUBMIT, code: '1, ctx: '1, param: 32'h8000_0000, delay: 0,
          amount: 0, room: 0, sidx: 0};
    send_beat(b);
    b.code = 0; b.ctx = 0; b.param = 32'h7FFF_FFFF; b.delay = '1;
    send_beat(b);
    for (int i = 0; i < 16; i++) begin
      b.delay = i + 1; b.code = $urandom(); send_beat(b);
    end
    b = '{cmd: CMD_ADVANCE, code: 0, ctx: 0, param: 0, delay: 0, amount: 8,
          room: 3, sidx: 0};
    send_beat(b);
    b.room = 31; b.amount = '1; send_beat(b);
    b.amount = '1; b.room = 16; send_beat(b);
    for (int i = 0; i < 8; i++) begin
      b = '{cmd: CMD_STAT, code: 0, ctx: 0, param: 0, delay: 0, amount: 0,
            room: 0, sidx: 3'(i)};
      send_beat(b);
    end
    b.cmd = CMD_NONE; send_beat(b);
    drain();
    write_post_mode(1);
    b = '{cmd: CMD_SUBMIT, code: 1, ctx: 2, param: 3, delay: 0, amount: 0,
          room: 0, sidx: 0};
    send_beat(b);
    b = '{cmd: CMD_ADVANCE, code: 0, ctx: 0, param: 0, delay: 0, amount: 0,
          room: 1, sidx: 0};
    send_beat(b);

    // Random phases alternating the post mode.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_post_mode(ph[0]);
      if (ph == 3) calm = 1;
      for (int n = 0; n < 72; n++) send_beat(rand_beat(ph == 1 ? 2 : 16));
    end

    drain();
    if (sb.errors == 0 && sb.pending_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
